// ===== rtl/tcpack_pkg.sv =====
package tcpack_pkg;

   // configuration register indexes
   localparam logic [2:0] RegMaxSegment  = 3'd0;
   localparam logic [2:0] RegSsthresh    = 3'd1;
   localparam logic [2:0] RegInitSrtt    = 3'd2;
   localparam logic [2:0] RegMsPerTick   = 3'd3;
   localparam logic [2:0] RegSrttGain    = 3'd4;
   localparam logic [2:0] RegMdevGain    = 3'd5;

   // configuration reset values
   localparam logic [15:0] MaxSegmentRst = 16'd536;
   localparam logic [15:0] SsthreshRst   = 16'd65535;
   localparam logic [15:0] InitSrttRst   = 16'd500;
   localparam logic [9:0]  MsPerTickRst  = 10'd50;
   localparam logic [6:0]  SrttGainRst   = 7'd8;
   localparam logic [6:0]  MdevGainRst   = 7'd4;

   // shared divider: dividend width covers (gain-1)*old + sample
   localparam int unsigned DivBits = 40;
   localparam int unsigned CntBits = $clog2(DivBits);
   localparam logic [CntBits-1:0] DivLast = CntBits'(DivBits - 1);

   localparam logic [15:0] WinMax = 16'hFFFF;

   localparam logic OpStart = 1'b0;
   localparam logic OpAck   = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_WIN,
      S_CWND,
      S_CMUL,
      S_CDIV,
      S_CGROW,
      S_RTT,
      S_RMUL,
      S_SMUL,
      S_SDIV,
      S_DMUL,
      S_DDIV,
      S_FIN,
      S_DONE
   } state_type;

endpackage

// ===== rtl/tcp_ack_update_cwnd_rtt.sv =====
// channel  | valid      | stall      | payload
// ---------+------------+------------+------------------------------------------
// request  | req_valid  | req_stall  | req_op .. req_handshaking
// response | rsp_valid  | rsp_stall  | rsp_force_send .. rsp_window_reopened
// config   | csr_wr_en  | (none)     | csr_index, csr_wdata
//
// A start item or a beyond/old ack goes from the window step straight to the result.
// A new ack may also run up to three divisions (cwnd growth, srtt filter,
// deviation filter) on the one shared bit-serial divider, each preceded by a
// pass through the shared multiplier.
// req_stall is high from transfer until the result is placed in the output
// register; a waiting result does not block the next request.
// Synchronous active-high reset clears the connection state to its defaults.
module tcp_ack_update_cwnd_rtt (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [31:0] req_ack_num,
   input  logic [31:0] req_seq_num,
   input  logic [15:0] req_peer_window,
   input  logic [31:0] req_send_next,
   input  logic        req_timing_active,
   input  logic [31:0] req_timed_seq,
   input  logic [15:0] req_elapsed_ticks,
   input  logic        req_retransmitted,
   input  logic        req_handshaking,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_force_send,
   output logic [15:0] rsp_bytes_acked,
   output logic [31:0] rsp_unacked_start,
   output logic [15:0] rsp_send_window,
   output logic [15:0] rsp_congestion_window,
   output logic [31:0] rsp_smoothed_rtt,
   output logic [31:0] rsp_rtt_deviation,
   output logic        rsp_retransmit_run,
   output logic        rsp_timing_stop,
   output logic        rsp_window_reopened
);
   import tcpack_pkg::*;

   // configuration registers
   logic [15:0] mss_ff, ssth_ff, init_srtt_ff;
   logic [9:0]  mpt_ff;
   logic [6:0]  sgain_ff, dgain_ff;

   // sequencer and connection state
   state_type   state_ff, state_in;
   logic [31:0] una_ff, una_in;
   logic [15:0] win_ff, win_in;
   logic [31:0] wl1_ff, wl1_in;
   logic [31:0] wl2_ff, wl2_in;
   logic [15:0] cwnd_ff, cwnd_in;
   logic [31:0] srtt_ff, srtt_in;
   logic [31:0] dev_ff, dev_in;
   logic        syn_ff, syn_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // per-item flags and working values
   logic        force_ff, force_in;
   logic [15:0] acked_ff, acked_in;
   logic        rrun_ff, rrun_in;
   logic        tstop_ff, tstop_in;
   logic        reopen_ff, reopen_in;
   logic [25:0] rtt_ff, rtt_in;
   logic [31:0] err_ff, err_in;

   // captured request
   logic        op_ff, timing_ff, retran_ff, hands_ff;
   logic [31:0] ack_ff, seq_ff, nxt_ff, tseq_ff;
   logic [15:0] wnd_ff, ticks_ff;

   // shared multiplier and divider
   logic [31:0] mul_a;
   logic [15:0] mul_b;
   logic [47:0] mul_ff;
   logic [DivBits-1:0] num_ff, num_in, num_step;
   logic [15:0]        rem_ff, rem_in, rem_step, den_ff, den_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic [16:0]        trial, trial_diff;
   logic               trial_ge;

   // output register
   logic        o_force_ff, o_rrun_ff, o_tstop_ff, o_reopen_ff;
   logic [15:0] o_acked_ff, o_win_ff, o_cwnd_ff;
   logic [31:0] o_una_ff, o_srtt_ff, o_dev_ff;

   logic        req_xfer, out_load;
   logic [6:0]  sgain_eff, dgain_eff;
   logic [31:0] d_ack_nxt, d_ack_wl2, d_seq_wl1, d_ack_una, d_ack_tseq;
   logic        ack_beyond, win_fresh, ack_new, rtt_done;
   logic [15:0] expand, ss_expand, div_expand;
   logic [16:0] grown_sum;
   logic [15:0] grown_sat, grown;
   logic [31:0] rtt_ext;

   assign req_xfer  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   // a gain of zero behaves as one
   assign sgain_eff = (sgain_ff == 7'd0) ? 7'd1 : sgain_ff;
   assign dgain_eff = (dgain_ff == 7'd0) ? 7'd1 : dgain_ff;

   // modulo 2^32 sequence comparisons
   assign d_ack_nxt  = ack_ff - nxt_ff;
   assign d_ack_wl2  = ack_ff - wl2_ff;
   assign d_seq_wl1  = seq_ff - wl1_ff;
   assign d_ack_una  = ack_ff - una_ff;
   assign d_ack_tseq = ack_ff - tseq_ff;
   assign ack_beyond = !d_ack_nxt[31] && (d_ack_nxt != 32'd0);
   assign win_fresh  = !d_ack_wl2[31] && !d_seq_wl1[31];
   assign ack_new    = !d_ack_una[31] && (d_ack_una != 32'd0);
   assign rtt_done   = timing_ff && !d_ack_tseq[31];

   // congestion window growth, saturated and limited to the send window
   assign ss_expand  = (acked_ff < mss_ff) ? acked_ff : mss_ff;
   assign div_expand = (|num_ff[DivBits-1:16]) ? WinMax : num_ff[15:0];
   always_comb begin
      case (state_ff)
         S_CGROW: expand = div_expand;
         default: expand = (cwnd_ff < ssth_ff) ? ss_expand : WinMax;
      endcase
   end
   assign grown_sum = {1'b0, cwnd_ff} + {1'b0, expand};
   assign grown_sat = grown_sum[16] ? WinMax : grown_sum[15:0];
   assign grown     = (grown_sat > win_ff) ? win_ff : grown_sat;

   assign rtt_ext = {6'd0, rtt_ff};

   // multiplier operand selection by sequencer step
   always_comb begin
      case (state_ff)
         S_RTT: begin
            mul_a = {16'd0, ticks_ff};
            mul_b = {6'd0, mpt_ff};
         end
         S_RMUL: begin
            mul_a = srtt_ff;
            mul_b = {9'd0, sgain_eff - 7'd1};
         end
         S_SDIV: begin
            mul_a = dev_ff;
            mul_b = {9'd0, dgain_eff - 7'd1};
         end
         default: begin
            mul_a = {16'd0, mss_ff};
            mul_b = mss_ff;
         end
      endcase
   end

   // one restoring divide step
   assign trial      = {rem_ff, num_ff[DivBits-1]};
   assign trial_ge   = (trial >= {1'b0, den_ff});
   assign trial_diff = trial - {1'b0, den_ff};
   assign rem_step   = trial_ge ? trial_diff[15:0] : trial[15:0];
   assign num_step   = {num_ff[DivBits-2:0], trial_ge};

   assign out_load = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // sequencer: next state and datapath updates
   always_comb begin
      state_in  = state_ff;
      una_in    = una_ff;
      win_in    = win_ff;
      wl1_in    = wl1_ff;
      wl2_in    = wl2_ff;
      cwnd_in   = cwnd_ff;
      srtt_in   = srtt_ff;
      dev_in    = dev_ff;
      syn_in    = syn_ff;
      force_in  = force_ff;
      acked_in  = acked_ff;
      rrun_in   = rrun_ff;
      tstop_in  = tstop_ff;
      reopen_in = reopen_ff;
      rtt_in    = rtt_ff;
      err_in    = err_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      cnt_in    = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               force_in  = 1'b0;
               acked_in  = 16'd0;
               rrun_in   = 1'b0;
               tstop_in  = 1'b0;
               reopen_in = 1'b0;
               state_in  = S_WIN;
            end
         end
         S_WIN: begin
            if (op_ff == OpStart) begin
               una_in   = ack_ff;
               wl2_in   = ack_ff;
               wl1_in   = seq_ff;
               win_in   = wnd_ff;
               cwnd_in  = mss_ff;
               srtt_in  = {16'd0, init_srtt_ff};
               dev_in   = 32'd0;
               syn_in   = 1'b0;
               state_in = S_DONE;
            end else if (ack_beyond) begin
               force_in = 1'b1;
               state_in = S_DONE;
            end else begin
               if (win_fresh) begin
                  reopen_in = (wnd_ff != 16'd0) && (win_ff == 16'd0);
                  win_in    = wnd_ff;
                  wl1_in    = seq_ff;
                  wl2_in    = ack_ff;
               end
               if (ack_new) begin
                  acked_in = d_ack_una[15:0];
                  state_in = S_CWND;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_CWND: begin
            // below the send window: slow start or zero window grows at once, else divide
            if (cwnd_ff < win_ff) begin
               if ((cwnd_ff < ssth_ff) || (cwnd_ff == 16'd0)) begin
                  cwnd_in  = grown;
                  state_in = S_RTT;
               end else begin
                  state_in = S_CMUL;
               end
            end else begin
               state_in = S_RTT;
            end
         end
         S_CMUL: begin
            num_in   = {{(DivBits-32){1'b0}}, mul_ff[31:0]};
            den_in   = cwnd_ff;
            rem_in   = 16'd0;
            cnt_in   = '0;
            state_in = S_CDIV;
         end
         S_CDIV: begin
            num_in = num_step;
            rem_in = rem_step;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DivLast) begin
               state_in = S_CGROW;
            end
         end
         S_CGROW: begin
            cwnd_in  = grown;
            state_in = S_RTT;
         end
         S_RTT: begin
            if (rtt_done) begin
               tstop_in = 1'b1;
               state_in = retran_ff ? S_FIN : S_RMUL;
            end else begin
               state_in = S_FIN;
            end
         end
         S_RMUL: begin
            rtt_in = mul_ff[25:0];
            if (({6'd0, mul_ff[25:0]} > srtt_ff) && hands_ff) begin
               srtt_in  = {6'd0, mul_ff[25:0]};
               state_in = S_FIN;
            end else begin
               err_in   = ({6'd0, mul_ff[25:0]} > srtt_ff) ?
                          ({6'd0, mul_ff[25:0]} - srtt_ff) :
                          (srtt_ff - {6'd0, mul_ff[25:0]});
               state_in = S_SMUL;
            end
         end
         S_SMUL: begin
            num_in   = mul_ff[DivBits-1:0] + {{(DivBits-32){1'b0}}, rtt_ext};
            den_in   = {9'd0, sgain_eff};
            rem_in   = 16'd0;
            cnt_in   = '0;
            state_in = S_SDIV;
         end
         S_SDIV: begin
            num_in = num_step;
            rem_in = rem_step;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DivLast) begin
               srtt_in  = num_step[31:0];
               state_in = S_DMUL;
            end
         end
         S_DMUL: begin
            num_in   = mul_ff[DivBits-1:0] + {{(DivBits-32){1'b0}}, err_ff};
            den_in   = {9'd0, dgain_eff};
            rem_in   = 16'd0;
            cnt_in   = '0;
            state_in = S_DDIV;
         end
         S_DDIV: begin
            num_in = num_step;
            rem_in = rem_step;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DivLast) begin
               dev_in   = num_step[31:0];
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // first new ack also covers the syn
            if (!syn_ff) begin
               syn_in   = 1'b1;
               acked_in = acked_ff - 16'd1;
            end
            una_in   = ack_ff;
            rrun_in  = (ack_ff != nxt_ff);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   // control and connection state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mss_ff       <= MaxSegmentRst;
         ssth_ff      <= SsthreshRst;
         init_srtt_ff <= InitSrttRst;
         mpt_ff       <= MsPerTickRst;
         sgain_ff     <= SrttGainRst;
         dgain_ff     <= MdevGainRst;
         una_ff       <= 32'd0;
         win_ff       <= 16'd0;
         wl1_ff       <= 32'd0;
         wl2_ff       <= 32'd0;
         cwnd_ff      <= MaxSegmentRst;
         srtt_ff      <= {16'd0, InitSrttRst};
         dev_ff       <= 32'd0;
         syn_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         una_ff       <= una_in;
         win_ff       <= win_in;
         wl1_ff       <= wl1_in;
         wl2_ff       <= wl2_in;
         cwnd_ff      <= cwnd_in;
         srtt_ff      <= srtt_in;
         dev_ff       <= dev_in;
         syn_ff       <= syn_in;
         if (csr_wr_en) begin
            case (csr_index)
               RegMaxSegment: mss_ff       <= csr_wdata;
               RegSsthresh:   ssth_ff      <= csr_wdata;
               RegInitSrtt:   init_srtt_ff <= csr_wdata;
               RegMsPerTick:  mpt_ff       <= csr_wdata[9:0];
               RegSrttGain:   sgain_ff     <= csr_wdata[6:0];
               RegMdevGain:   dgain_ff     <= csr_wdata[6:0];
               default: ;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      force_ff  <= force_in;
      acked_ff  <= acked_in;
      rrun_ff   <= rrun_in;
      tstop_ff  <= tstop_in;
      reopen_ff <= reopen_in;
      rtt_ff    <= rtt_in;
      err_ff    <= err_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      cnt_ff    <= cnt_in;
      mul_ff    <= mul_a * mul_b;
      // request capture on transfer
      if (req_xfer) begin
         op_ff     <= req_op;
         ack_ff    <= req_ack_num;
         seq_ff    <= req_seq_num;
         wnd_ff    <= req_peer_window;
         nxt_ff    <= req_send_next;
         timing_ff <= req_timing_active;
         tseq_ff   <= req_timed_seq;
         ticks_ff  <= req_elapsed_ticks;
         retran_ff <= req_retransmitted;
         hands_ff  <= req_handshaking;
      end
      // output register load
      if (out_load) begin
         o_force_ff  <= force_ff;
         o_acked_ff  <= acked_ff;
         o_una_ff    <= una_ff;
         o_win_ff    <= win_ff;
         o_cwnd_ff   <= cwnd_ff;
         o_srtt_ff   <= srtt_ff;
         o_dev_ff    <= dev_ff;
         o_rrun_ff   <= rrun_ff;
         o_tstop_ff  <= tstop_ff;
         o_reopen_ff <= reopen_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_force_send        = o_force_ff;
   assign rsp_bytes_acked       = o_acked_ff;
   assign rsp_unacked_start     = o_una_ff;
   assign rsp_send_window       = o_win_ff;
   assign rsp_congestion_window = o_cwnd_ff;
   assign rsp_smoothed_rtt      = o_srtt_ff;
   assign rsp_rtt_deviation     = o_dev_ff;
   assign rsp_retransmit_run    = o_rrun_ff;
   assign rsp_timing_stop       = o_tstop_ff;
   assign rsp_window_reopened   = o_reopen_ff;

endmodule

// ===== rtl/tcpack_chk.sv =====
module tcpack_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_force_send,
   input logic [15:0] rsp_bytes_acked,
   input logic [31:0] rsp_unacked_start,
   input logic        rsp_retransmit_run,
   input logic        rsp_timing_stop,
   input logic        rsp_window_reopened
);

   // a stalled result stays offered, with unacked start and bytes acked unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_unacked_start)
         && $stable(rsp_bytes_acked))
      else $error("stalled response changed");

   // one request in flight: busy right after a transfer
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // a forced send changes nothing else
   a_force: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_force_send |-> rsp_bytes_acked == 16'd0
         && !rsp_retransmit_run && !rsp_timing_stop && !rsp_window_reopened)
      else $error("force send with other actions");

   // no result right out of reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind tcp_ack_update_cwnd_rtt tcpack_chk u_tcpack_chk (.*);
